// ===== rtl/utf8_to_utf16_transcoder_assert.svh =====
// Assertion macros used by the transcoder checker.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define U8U16_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("transcoder assertion failed");

// Check cons in the cycle after ante holds.
`define U8U16_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("transcoder assertion failed");

`endif

// ===== rtl/u8u16_pkg.sv =====
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
package u8u16_pkg;

	localparam logic [1:0] KIND_UNIT  = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Open sequence length codes
	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_2B   = 2'd1;
	localparam logic [1:0] SEQ_3B   = 2'd2;
	localparam logic [1:0] SEQ_4B   = 2'd3;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [15:0] unit;
		logic [1:0]  kind;
	} res_t;

	// Results caused by one byte, entry 0 goes out first
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         cnt;
	} res_bundle_t;

endpackage

// ===== rtl/u8u16_decode.sv =====
// Per-byte UTF-8 decoder with sequence state and UTF-16 unit generation.
module u8u16_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             byte_in,
	input  logic                   end_of_string,
	output u8u16_pkg::res_bundle_t bundle
);
	import u8u16_pkg::*;

	logic [1:0]  rem_q, rem_n;
	logic [1:0]  seq_q, seq_n;
	logic [20:0] acc_q, acc_n;
	logic        err_q, err_n;

	logic        bad;
	logic        emit;
	logic        fail;
	logic [20:0] scalar;
	logic [20:0] acc_shift;
	logic [20:0] off;
	logic [1:0]  n;

	assign acc_shift = {acc_q[14:0], byte_in[5:0]};
	assign off       = scalar - 21'h010000;

	always_comb begin
		rem_n  = rem_q;
		seq_n  = seq_q;
		acc_n  = acc_q;
		err_n  = err_q;
		bad    = 1'b0;
		emit   = 1'b0;
		fail   = 1'b0;
		scalar = '0;
		n      = 2'd0;
		bundle = '0;

		if (!err_q) begin
			if (rem_q == 2'd0) begin
				if (!byte_in[7]) begin
					emit   = 1'b1;
					scalar = {13'd0, byte_in};
				end else if (byte_in[7:5] == 3'b110) begin
					acc_n = {16'd0, byte_in[4:0]};
					rem_n = 2'd1;
					seq_n = SEQ_2B;
				end else if (byte_in[7:4] == 4'b1110) begin
					acc_n = {17'd0, byte_in[3:0]};
					rem_n = 2'd2;
					seq_n = SEQ_3B;
				end else if (byte_in[7:3] == 5'b11110) begin
					acc_n = {18'd0, byte_in[2:0]};
					rem_n = 2'd3;
					seq_n = SEQ_4B;
				end else begin
					bad = 1'b1;
				end
			end else if (byte_in[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				acc_n = acc_shift;
				rem_n = rem_q - 2'd1;
				if (rem_n == 2'd0) begin
					scalar = acc_shift;
					unique case (seq_q)
						SEQ_2B: bad = acc_shift < 21'h000080;
						SEQ_3B: bad = (acc_shift < 21'h000800) ||
							((acc_shift >= 21'h00D800) && (acc_shift <= 21'h00DFFF));
						default: bad = (acc_shift < 21'h010000) || (acc_shift > 21'h10FFFF);
					endcase
					seq_n = SEQ_NONE;
					acc_n = '0;
					emit  = !bad;
				end
			end
			if (bad) begin
				err_n = 1'b1;
				rem_n = 2'd0;
				seq_n = SEQ_NONE;
				acc_n = '0;
			end
		end

		if (emit) begin
			if (scalar <= 21'h00FFFF) begin
				bundle.res[0] = '{unit: scalar[15:0], kind: KIND_UNIT};
				n = 2'd1;
			end else begin
				// Split into a surrogate pair
				bundle.res[0] = '{unit: 16'hD800 | {6'd0, off[19:10]}, kind: KIND_UNIT};
				bundle.res[1] = '{unit: 16'hDC00 | {6'd0, off[9:0]}, kind: KIND_UNIT};
				n = 2'd2;
			end
		end

		if (end_of_string) begin
			fail = err_n || (rem_n != 2'd0);
			if (fail) begin
				n = 2'd0;
			end
			bundle.res[n] = '{unit: 16'd0, kind: fail ? KIND_ERROR : KIND_OK};
			n = n + 2'd1;
			rem_n = 2'd0;
			seq_n = SEQ_NONE;
			acc_n = '0;
			err_n = 1'b0;
		end
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			seq_q <= SEQ_NONE;
			acc_q <= '0;
			err_q <= 1'b0;
		end else if (advance) begin
			rem_q <= rem_n;
			seq_q <= seq_n;
			acc_q <= acc_n;
			err_q <= err_n;
		end
	end

endmodule

// ===== rtl/u8u16_outbuf.sv =====
// Result register that holds the results of one byte and sends them one beat each.
module u8u16_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  u8u16_pkg::res_bundle_t bundle,
	output logic                   free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // [15:0] code_unit
	output logic [1:0]             m_tuser,   // [1:0] kind
	output logic                   m_tlast    // last_of_run
);
	import u8u16_pkg::*;

	res_t [MAX_RES-1:0] res_q;
	logic [1:0]         cnt_q;
	logic [1:0]         idx_q;
	logic               busy_q;
	logic               at_end;

	assign at_end   = (idx_q == (cnt_q - 2'd1));
	assign free     = !busy_q || (m_tready && at_end);
	assign m_tvalid = busy_q;
	assign m_tdata  = res_q[idx_q].unit;
	assign m_tuser  = res_q[idx_q].kind;
	assign m_tlast  = at_end;

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= bundle.res;
			cnt_q <= bundle.cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load && free) begin
			// Bytes that cause no result leave the buffer empty
			busy_q <= (bundle.cnt != 2'd0);
			idx_q  <= 2'd0;
		end else if (busy_q && m_tready) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder top level.
// Takes one UTF-8 byte per beat on the s_ side, tlast marking the final byte of a string,
// and sends UTF-16 code units on the m_ side with kind in tuser: 0 code unit, 1 string ok,
// 2 string in error; m_tlast marks the last result caused by a byte. A byte passes an input
// register, then the decoder, and its results land in the output register once that register
// is free. One byte is taken per cycle as long as m_tready stays high and each byte yields at
// most one result; a byte that completes a scalar above 0xFFFF, or ends a string after a unit,
// yields two or three results and holds the input until they are sent, since the output
// register sends one result per beat. A string in error still may have sent units before
// its error result; discard them on seeing the error result.
module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last_of_run
);
	import u8u16_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        free;
	logic        advance;
	res_bundle_t bundle;

	assign advance  = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	u8u16_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.byte_in      (byte_s1),
		.end_of_string(last_s1),
		.bundle       (bundle)
	);

	u8u16_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (valid_s1),
		.bundle  (bundle),
		.free    (free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== rtl/u8u16_checker.sv =====
// Port-level checks on the transcoder output stream, bound to the top level.
`include "utf8_to_utf16_transcoder_assert.svh"

module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import u8u16_pkg::*;

	// Hold a stalled beat
	`U8U16_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// End results close their run and carry no unit
	`U8U16_ASSERT_NOW(a_end_last, m_tvalid && (m_tuser != KIND_UNIT), m_tlast && (m_tdata == 16'd0))
	// A high surrogate never ends a run
	`U8U16_ASSERT_NOW(a_high_open, m_tvalid && (m_tuser == KIND_UNIT) && (m_tdata[15:10] == 6'b110110), !m_tlast)
	// A low surrogate follows a high one on the very next cycle
	`U8U16_ASSERT_NEXT(a_pair, m_tvalid && m_tready && (m_tuser == KIND_UNIT) && (m_tdata[15:10] == 6'b110110), m_tvalid && (m_tuser == KIND_UNIT) && (m_tdata[15:10] == 6'b110111))

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// ===== verif/utf8_to_utf16_transcoder_test.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_test;
	import u8u16_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [15:0] code;
		logic [1:0]  kind;
		logic        is_last;
	} u16_beat_t;

	typedef enum int {
		FLT_OVERLONG,
		FLT_SURROGATE,
		FLT_ABOVE_MAX,
		FLT_BAD_LEAD,
		FLT_BAD_CONT,
		FLT_TRUNCATED
	} fault_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// decoder state mirrored by the predictor
	logic [1:0]  cont_left;
	logic [1:0]  seq_code;
	logic [20:0] scalar_acc;
	logic        err_flag;

	u16_beat_t   byte_results[$];
	u16_beat_t   expected_units[$];
	logic [7:0]  string_bytes[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	utf8_to_utf16_transcoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_beat(input u16_beat_t r);
		byte_results.insert(byte_results.size(), r);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		string_bytes.insert(string_bytes.size(), b);
	endfunction

	function automatic void push_scalar_units(input logic [20:0] s);
		logic [20:0] off;
		if (s <= 21'h00FFFF) begin
			add_beat('{s[15:0], KIND_UNIT, 1'b0});
		end else begin
			off = s - 21'h010000;
			add_beat('{16'hD800 + {6'd0, off[19:10]}, KIND_UNIT, 1'b0});
			add_beat('{16'hDC00 + {6'd0, off[9:0]}, KIND_UNIT, 1'b0});
		end
	endfunction

	// Predict the beats caused by one accepted byte and queue them.
	function automatic void transcode_byte(input logic [7:0] b, input logic is_end);
		logic        bad;
		logic [20:0] s;
		bad = 1'b0;
		byte_results.delete();
		if (!err_flag) begin
			if (cont_left == 2'd0) begin
				if (b < 8'h80) begin
					push_scalar_units({13'd0, b});
				end else if ((b & 8'hE0) == 8'hC0) begin
					scalar_acc = {16'd0, b[4:0]};
					cont_left = 2'd1;
					seq_code = SEQ_2B;
				end else if ((b & 8'hF0) == 8'hE0) begin
					scalar_acc = {17'd0, b[3:0]};
					cont_left = 2'd2;
					seq_code = SEQ_3B;
				end else if ((b & 8'hF8) == 8'hF0) begin
					scalar_acc = {18'd0, b[2:0]};
					cont_left = 2'd3;
					seq_code = SEQ_4B;
				end else begin
					bad = 1'b1;
				end
			end else if ((b & 8'hC0) != 8'h80) begin
				bad = 1'b1;
			end else begin
				scalar_acc = {scalar_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					s = scalar_acc;
					case (seq_code)
						SEQ_2B: bad = s < 21'h80;
						SEQ_3B: bad = s < 21'h800 || (s >= 21'hD800 && s <= 21'hDFFF);
						default: bad = s < 21'h10000 || s > 21'h10FFFF;
					endcase
					seq_code = SEQ_NONE;
					scalar_acc = '0;
					if (!bad)
						push_scalar_units(s);
				end
			end
			if (bad) begin
				byte_results.delete();
				err_flag = 1'b1;
				cont_left = 2'd0;
				seq_code = SEQ_NONE;
				scalar_acc = '0;
			end
		end
		if (is_end) begin
			if (err_flag || cont_left != 2'd0) begin
				byte_results.delete();
				add_beat('{16'd0, KIND_ERROR, 1'b0});
			end else begin
				add_beat('{16'd0, KIND_OK, 1'b0});
			end
			cont_left = 2'd0;
			seq_code = SEQ_NONE;
			scalar_acc = '0;
			err_flag = 1'b0;
		end
		foreach (byte_results[i]) begin
			u16_beat_t r;
			r = byte_results[i];
			r.is_last = (i == byte_results.size() - 1);
			expected_units.insert(expected_units.size(), r);
		end
	endfunction

	// Encode a scalar in nb bytes, keeping only the first keep of them.
	function automatic void append_utf8(input logic [20:0] cp, input int nb, input int keep);
		logic [7:0] enc [4];
		enc[0] = {1'b0, cp[6:0]};
		enc[1] = 8'h80;
		enc[2] = 8'h80;
		enc[3] = 8'h80;
		case (nb)
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			4: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
			default: ;
		endcase
		for (int i = 0; i < keep; i++)
			add_byte(enc[i]);
	endfunction

	function automatic logic [20:0] random_scalar(input int nb);
		logic [20:0] cp;
		case (nb)
			1: cp = 21'($urandom_range(0, 'h7F));
			2: cp = 21'($urandom_range('h80, 'h7FF));
			3: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				// move surrogates into the top of the plane
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp = cp ^ 21'h2000;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	function automatic void append_fault(input fault_e kind);
		int          nb;
		int          pos;
		logic [1:0]  top;
		logic [20:0] cp;
		nb = $urandom_range(2, 4);
		case (kind)
			FLT_OVERLONG: begin
				cp = 21'((nb == 2) ? $urandom_range(0, 'h7F) :
				         (nb == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF));
				append_utf8(cp, nb, nb);
			end
			FLT_SURROGATE: append_utf8(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
			FLT_ABOVE_MAX: append_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
			FLT_BAD_LEAD: begin
				if ($urandom_range(1))
					add_byte(8'($urandom_range('h80, 'hBF)));
				else
					add_byte(8'($urandom_range('hF8, 'hFF)));
			end
			FLT_BAD_CONT: begin
				append_utf8(random_scalar(nb), nb, nb);
				pos = string_bytes.size() - $urandom_range(1, nb - 1);
				top = 2'($urandom_range(0, 2));
				if (top == 2'd2)
					top = 2'd3;
				string_bytes[pos] = {top, 6'($urandom)};
			end
			default: append_utf8(random_scalar(nb), nb, $urandom_range(1, nb - 1));
		endcase
	endfunction

	// Fill string_bytes with one random string: mostly well formed, some faulty, some noise.
	function automatic void build_random_string();
		int     mode;
		int     nsc;
		int     fault_at;
		int     nb;
		fault_e kind;
		string_bytes.delete();
		mode = $urandom_range(99);
		if (mode < 10) begin
			repeat ($urandom_range(1, 6))
				add_byte(8'($urandom));
			return;
		end
		nsc = $urandom_range(1, 5);
		fault_at = -1;
		kind = fault_e'($urandom_range(0, 5));
		if (mode < 35)
			fault_at = (kind == FLT_TRUNCATED) ? nsc : $urandom_range(0, nsc - 1);
		for (int i = 0; i <= nsc; i++) begin
			if (i == fault_at) begin
				append_fault(kind);
			end else if (i < nsc) begin
				nb = $urandom_range(99);
				nb = (nb < 30) ? 1 : (nb < 55) ? 2 : (nb < 80) ? 3 : 4;
				append_utf8(random_scalar(nb), nb, nb);
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic is_end);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= is_end;
		do
			@(posedge clk);
		while (!s_tready);
		transcode_byte(b, is_end);
	endtask

	task automatic send_string();
		foreach (string_bytes[i])
			send_byte(string_bytes[i], i == string_bytes.size() - 1);
	endtask

	task automatic test_directed();
		// 1-/2-byte extremes, 3-/4-byte maxima, ending in a surrogate pair plus ok
		string_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
		                 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_string();
		// bad lead at the start of the string, then a dropped byte, then the end
		string_bytes = '{8'hFF, 8'h41, 8'h80};
		send_string();
		// surrogate completed on the last byte
		string_bytes = '{8'hED, 8'hA0, 8'h80};
		send_string();
		// bad continuation on the last byte
		string_bytes = '{8'hC3, 8'h41};
		send_string();
		// sequence cut short by the end
		string_bytes = '{8'hF0, 8'h90};
		send_string();
		// value above the code space
		string_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
		send_string();
	endtask

	task automatic test_random_strings(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			build_random_string();
			send_string();
			sent += string_bytes.size();
		end
	endtask

	function automatic void report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Check each output beat against the oldest prediction.
	always @(posedge clk) begin
		u16_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_units.size() == 0) begin
				report_mismatch($sformatf("unexpected beat unit=%h kind=%0d last=%b",
				                          m_tdata, m_tuser, m_tlast));
			end else begin
				want = expected_units.pop_front();
				if (m_tdata !== want.code || m_tuser !== want.kind || m_tlast !== want.is_last)
					report_mismatch($sformatf(
						"expected unit=%h kind=%0d last=%b, got unit=%h kind=%0d last=%b",
						want.code, want.kind, want.is_last, m_tdata, m_tuser, m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("utf8_to_utf16_transcoder regression: fail");
				$finish;
			end
		end
	end

	initial begin
		cont_left = 2'd0;
		seq_code = SEQ_NONE;
		scalar_acc = '0;
		err_flag = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 36;
		rx_stall_pct = 71;
		test_directed();
		test_random_strings(110);

		tx_idle_pct = 71;
		rx_stall_pct = 36;
		test_random_strings(110);

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		test_random_strings(110);

		s_tvalid <= 1'b0;
		wait (expected_units.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_units.size() == 0)
			$display("utf8_to_utf16_transcoder regression: pass");
		else
			$display("utf8_to_utf16_transcoder regression: fail");
		$finish;
	end

endmodule
